// ===== rtl/core/mqtt_packet_parser_responder_top_macros.svh =====
// assertion macros shared by the checker
`ifndef MQTT_PACKET_PARSER_RESPONDER_TOP_MACROS_SVH
`define MQTT_PACKET_PARSER_RESPONDER_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define MPP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mpp check failed");

// next-cycle implication, quiet during reset
`define MPP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mpp check failed");

`endif

// ===== rtl/core/mpp_pkg.sv =====
// shared types, codes and helpers of the packet parser and responder
package mpp_pkg;

    localparam int MPP_MAX_SUBS = 60;
    localparam int MPP_QDEPTH   = 4;
    localparam int CNT_W        = 6;

    localparam logic [1:0] PH_CLOSED = 2'd0;
    localparam logic [1:0] PH_FIXED  = 2'd1;
    localparam logic [1:0] PH_LENGTH = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    localparam logic [3:0] T_CONNECT    = 4'd1;
    localparam logic [3:0] T_PUBLISH    = 4'd3;
    localparam logic [3:0] T_SUBSCRIBE  = 4'd8;
    localparam logic [3:0] T_PINGREQ    = 4'd12;
    localparam logic [3:0] T_DISCONNECT = 4'd14;

    localparam logic [2:0] K_BYTE       = 3'd0;
    localparam logic [2:0] K_ERROR      = 3'd1;
    localparam logic [2:0] K_PUBLISH    = 3'd2;
    localparam logic [2:0] K_DISCONNECT = 3'd3;
    localparam logic [2:0] K_SUBSCRIBED = 3'd4;

    localparam logic [2:0] A_NONE    = 3'd0;
    localparam logic [2:0] A_ERROR   = 3'd1;
    localparam logic [2:0] A_PUBLISH = 3'd2;
    localparam logic [2:0] A_DISC    = 3'd3;
    localparam logic [2:0] A_CONNACK = 3'd4;
    localparam logic [2:0] A_PING    = 3'd5;
    localparam logic [2:0] A_SUBACK  = 3'd6;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] out_kind;
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // one unit of response work handed from the parser to the responder
    typedef struct packed {
        logic             sub;
        logic [2:0]       act;
        logic [CNT_W-1:0] cnt;
        logic [15:0]      pid;
    } t_job;

    function automatic logic [3:0] var_header_len(input logic [3:0] t);
        logic [3:0] v;
        v = 4'd0;
        if (t == T_CONNECT) v = 4'd10;
        else if (t == T_PUBLISH || t == T_SUBSCRIBE) v = 4'd2;
        return v;
    endfunction

    function automatic logic flags_ok(input logic [3:0] t, input logic [3:0] f);
        logic ok;
        if (t == 4'd0 || t == 4'd15) ok = 1'b0;
        else if (t == 4'd6 || t == 4'd8 || t == 4'd10) ok = (f == 4'd2);
        else ok = (f == 4'd0);
        return ok;
    endfunction

    function automatic logic [7:0] proto_head(input logic [2:0] i);
        logic [7:0] v;
        unique case (i)
            3'd0:    v = 8'h00;
            3'd1:    v = 8'h04;
            3'd2:    v = 8'h4D;
            3'd3:    v = 8'h51;
            3'd4:    v = 8'h54;
            3'd5:    v = 8'h54;
            3'd6:    v = 8'h04;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/mpp_front.sv =====
// byte parser: framing, header checks and subscribe entry walk
module mpp_front #(
    parameter int MAX_SUBS = 60
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  mpp_pkg::t_in_item i_item,
    output logic              o_job_valid,
    output mpp_pkg::t_job     o_job
);
    import mpp_pkg::*;

    logic [1:0]       r_phase, n_phase;
    logic [3:0]       r_type, n_type;
    logic [20:0]      r_lval, n_lval;
    logic [1:0]       r_lcnt, n_lcnt;
    logic [20:0]      r_left, n_left;
    logic [3:0]       r_hidx, n_hidx;
    logic             r_conn, n_conn;
    logic [15:0]      r_pid, n_pid;
    logic [1:0]       r_ep, n_ep;
    logic [15:0]      r_tleft, n_tleft;
    logic [CNT_W-1:0] r_scnt, n_scnt;
    logic             r_stop, n_stop;
    logic             r_bad, n_bad;

    logic             do_err, do_fin, sub_ev;
    logic [2:0]       act;
    logic [7:0]       b;
    logic [20:0]      lv, part;
    logic [3:0]       vlen;
    logic [15:0]      tl;
    logic [CNT_W-1:0] jcnt;
    logic [15:0]      jpid;

    always_comb begin
        n_phase = r_phase; n_type = r_type; n_lval = r_lval; n_lcnt = r_lcnt;
        n_left = r_left; n_hidx = r_hidx; n_conn = r_conn; n_pid = r_pid;
        n_ep = r_ep; n_tleft = r_tleft; n_scnt = r_scnt; n_stop = r_stop;
        n_bad = r_bad;
        do_err = 1'b0; do_fin = 1'b0; sub_ev = 1'b0; act = A_NONE;
        b = i_item.rx_byte;
        vlen = var_header_len(r_type);
        lv = '0; part = '0; tl = '0;
        jcnt = '0; jpid = '0;

        if (i_valid && i_item.command) begin
            n_type = '0; n_lval = '0; n_lcnt = '0; n_left = '0; n_hidx = '0;
            n_pid = '0; n_ep = '0; n_tleft = '0; n_scnt = '0; n_stop = 1'b0;
            n_bad = 1'b0; n_conn = 1'b0; n_phase = PH_FIXED;
        end else if (i_valid) begin
            unique case (r_phase)
                PH_FIXED: begin
                    n_type = b[7:4];
                    if (!flags_ok(b[7:4], b[3:0])) do_err = 1'b1;
                    else n_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    if (r_lcnt == 2'd3) begin
                        do_err = 1'b1;
                    end else begin
                        unique case (r_lcnt)
                            2'd0:    part = {14'd0, b[6:0]};
                            2'd1:    part = {7'd0, b[6:0], 7'd0};
                            default: part = {b[6:0], 14'd0};
                        endcase
                        lv = r_lval + part;
                        n_lval = lv;
                        n_lcnt = r_lcnt + 2'd1;
                        if (!b[7]) begin
                            if (lv < {17'd0, vlen}) begin
                                do_err = 1'b1;
                            end else begin
                                n_left = lv;
                                n_hidx = '0;
                                if (lv == '0) do_fin = 1'b1;
                                else n_phase = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (r_hidx < vlen) begin
                        if (r_type == T_CONNECT) begin
                            if (r_hidx < 4'd7) begin
                                if (b != proto_head(r_hidx[2:0])) n_bad = 1'b1;
                            end else if (r_hidx == 4'd7) begin
                                if ((b & 8'h05) != 8'h00) n_bad = 1'b1;
                            end
                        end else if (r_type == T_SUBSCRIBE) begin
                            n_pid = {r_pid[7:0], b};
                        end
                        n_hidx = r_hidx + 4'd1;
                    end else if (r_type == T_SUBSCRIBE && r_conn && !r_stop) begin
                        // one step of the entry walk per byte
                        unique case (r_ep)
                            2'd0: begin
                                if (r_left < 21'd2 || r_scnt >= CNT_W'(MAX_SUBS)) begin
                                    n_stop = 1'b1;
                                end else begin
                                    n_tleft = {b, 8'h00};
                                    n_ep = 2'd1;
                                end
                            end
                            2'd1: begin
                                tl = r_tleft | {8'h00, b};
                                n_tleft = tl;
                                n_ep = (tl != '0) ? 2'd2 : 2'd3;
                            end
                            2'd2: begin
                                tl = r_tleft - 16'd1;
                                n_tleft = tl;
                                if (tl == '0) n_ep = 2'd3;
                            end
                            default: begin
                                if (b != 8'h00) begin
                                    n_stop = 1'b1;
                                end else begin
                                    n_scnt = r_scnt + CNT_W'(1);
                                    sub_ev = 1'b1;
                                end
                                n_ep = 2'd0;
                            end
                        endcase
                    end
                    n_left = r_left - 21'd1;
                    if (n_left == '0) do_fin = 1'b1;
                end
                default: ;
            endcase

            jcnt = n_scnt;
            jpid = n_pid;

            if (do_fin) begin
                if (r_type == T_CONNECT) begin
                    if (n_bad) do_err = 1'b1;
                    else begin
                        act = A_CONNACK;
                        n_conn = 1'b1;
                    end
                end else if (r_conn) begin
                    priority if (r_type == T_PUBLISH)    act = A_PUBLISH;
                    else if (r_type == T_DISCONNECT)     act = A_DISC;
                    else if (r_type == T_SUBSCRIBE)      act = A_SUBACK;
                    else if (r_type == T_PINGREQ)        act = A_PING;
                    else                                 act = A_NONE;
                end
            end
            if (do_fin || do_err) begin
                n_type = '0; n_lval = '0; n_lcnt = '0; n_left = '0; n_hidx = '0;
                n_pid = '0; n_ep = '0; n_tleft = '0; n_scnt = '0; n_stop = 1'b0;
                n_bad = 1'b0; n_phase = PH_FIXED;
            end
            if (do_err) begin
                act = A_ERROR;
                n_conn = 1'b0;
                n_phase = PH_CLOSED;
            end
        end
    end

    assign o_job.sub  = sub_ev;
    assign o_job.act  = act;
    assign o_job.cnt  = jcnt;
    assign o_job.pid  = jpid;
    // suback counts and id are taken before the clear
    always_comb begin
        o_job_valid = i_valid && (sub_ev || act != A_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CLOSED; r_type <= '0; r_lval <= '0; r_lcnt <= '0;
            r_left <= '0; r_hidx <= '0; r_conn <= 1'b0; r_pid <= '0;
            r_ep <= '0; r_tleft <= '0; r_scnt <= '0; r_stop <= 1'b0;
            r_bad <= 1'b0;
        end else begin
            r_phase <= n_phase; r_type <= n_type; r_lval <= n_lval; r_lcnt <= n_lcnt;
            r_left <= n_left; r_hidx <= n_hidx; r_conn <= n_conn; r_pid <= n_pid;
            r_ep <= n_ep; r_tleft <= n_tleft; r_scnt <= n_scnt; r_stop <= n_stop;
            r_bad <= n_bad;
        end
    end

endmodule

// ===== rtl/core/mpp_queue.sv =====
// small job queue between parser and responder
module mpp_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mpp_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output mpp_pkg::t_job o_job
);
    import mpp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          wr_en, rd_en;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_job   = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (rd_en) r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            r_cnt <= r_cnt + CW'(wr_en) - CW'(rd_en);
        end
    end

endmodule

// ===== rtl/core/mpp_back.sv =====
// responder: expands one job into its result sequence
module mpp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  mpp_pkg::t_job      i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output mpp_pkg::t_out_item o_res
);
    import mpp_pkg::*;

    logic       r_busy;
    t_job       r_job;
    logic [6:0] r_idx;
    logic [6:0] len, total, j;
    logic       is_last, load;

    always_comb begin
        unique case (r_job.act)
            A_CONNACK: len = 7'd4;
            A_PING:    len = 7'd2;
            A_SUBACK:  len = 7'd4 + {1'b0, r_job.cnt};
            A_NONE:    len = 7'd0;
            default:   len = 7'd1;
        endcase
        total   = len + {6'd0, r_job.sub};
        is_last = (r_idx == total - 7'd1);
        j       = r_idx - {6'd0, r_job.sub};
    end

    always_comb begin
        o_res.last     = is_last;
        o_res.out_byte = 8'h00;
        o_res.out_kind = K_BYTE;
        if (r_job.sub && r_idx == 7'd0) begin
            o_res.out_kind = K_SUBSCRIBED;
        end else begin
            unique case (r_job.act)
                A_ERROR:   o_res.out_kind = K_ERROR;
                A_PUBLISH: o_res.out_kind = K_PUBLISH;
                A_DISC:    o_res.out_kind = K_DISCONNECT;
                A_CONNACK: begin
                    if (j == 7'd0) o_res.out_byte = 8'h20;
                    else if (j == 7'd1) o_res.out_byte = 8'h02;
                end
                A_PING: if (j == 7'd0) o_res.out_byte = 8'hD0;
                A_SUBACK: begin
                    unique case (j)
                        7'd0:    o_res.out_byte = 8'h90;
                        7'd1:    o_res.out_byte = {2'b00, r_job.cnt} + 8'd2;
                        7'd2:    o_res.out_byte = r_job.pid[15:8];
                        7'd3:    o_res.out_byte = r_job.pid[7:0];
                        default: o_res.out_byte = 8'h00;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_empty   = !r_busy;
    assign load      = !r_busy || (i_pop && is_last);
    assign o_job_pop = load && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (o_job_pop) r_job <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= i_job_valid;
            r_idx  <= '0;
        end else if (i_pop) begin
            r_idx <= r_idx + 7'd1;
        end
    end

endmodule

// ===== rtl/core/mqtt_packet_parser_responder_top.sv =====
// a request's first result passes the job queue and then the responder's job register on
// its way to the result ports; throughput: one request per cycle while full is low;
// results leave one per cycle while pop is high, a job of n results holds the responder
// until all n are popped, and a four-entry job queue absorbs bursts before full rises
// reset: synchronous active-low i_rst_n closes the session and empties the queue
module mqtt_packet_parser_responder_top #(
    parameter int MAX_SUBS = mpp_pkg::MPP_MAX_SUBS,
    parameter int QDEPTH   = mpp_pkg::MPP_QDEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  mpp_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output mpp_pkg::t_out_item o_res
);
    import mpp_pkg::*;

    logic front_valid, q_valid, q_pop;
    t_job front_job, q_job;

    mpp_front #(.MAX_SUBS(MAX_SUBS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(push && !full), .i_item,
        .o_job_valid(front_valid), .o_job(front_job)
    );

    mpp_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_push(front_valid), .i_job(front_job),
        .i_pop(q_pop), .o_valid(q_valid), .o_full(full), .o_job(q_job)
    );

    mpp_back u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(q_valid), .i_job(q_job), .o_job_pop(q_pop),
        .o_empty(empty), .i_pop(pop), .o_res
    );

endmodule

// ===== rtl/core/mpp_checker.sv =====
// port-level checks on the packet parser and responder
`include "mqtt_packet_parser_responder_top_macros.svh"
module mpp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input mpp_pkg::t_out_item o_res
);
    import mpp_pkg::*;

    `MPP_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(o_res))
    `MPP_ASSERT_IMP(a_kind, !empty, o_res.out_kind <= K_SUBSCRIBED)
    `MPP_ASSERT_IMP(a_zero, !empty && o_res.out_kind != K_BYTE, o_res.out_byte == 8'h00)
    `MPP_ASSERT_IMP(a_evlast, !empty && o_res.out_kind != K_BYTE && o_res.out_kind != K_SUBSCRIBED, o_res.last)

endmodule

bind mqtt_packet_parser_responder_top mpp_checker u_mpp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop), .o_res(o_res)
);
